>>> sv/ant32_pkg.sv
// Shared types and constants for the ASCII number parser.
// Used by the front classifier, the item queue, the back accumulator and the checker.
package ant32_pkg;

    // radix register codes; the fourth code acts as decimal
    localparam logic [1:0] RADIX_BIN     = 2'd0;
    localparam logic [1:0] RADIX_HEX     = 2'd1;
    localparam logic [1:0] RADIX_DEC     = 2'd2;
    localparam logic [1:0] RADIX_RESET   = RADIX_DEC;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FORMAT = 2'd1,
        ST_LENGTH = 2'd2,
        ST_RANGE  = 2'd3
    } status_t;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int          ACC_W      = 33;
    localparam int          PROD_W     = 37;
    localparam logic [36:0] DEC_LIMIT  = 37'h0_8000_0000;
    localparam logic [32:0] POS_MAX    = 33'h0_7FFF_FFFF;
    localparam logic [8:0]  BIN_LEN    = 9'd32;
    localparam logic [8:0]  HEX_LEN    = 9'd8;

    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_ONE    = 8'h31;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_LC_A   = 8'h61;
    localparam logic [7:0] CHAR_LC_F   = 8'h66;
    localparam logic [7:0] CHAR_UC_A   = 8'h41;
    localparam logic [7:0] CHAR_UC_F   = 8'h46;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;

    // one classified character on its way from front to back
    typedef struct packed {
        logic [1:0] radix;
        logic       digit_ok;
        logic [3:0] digit;
        logic       is_minus;
        logic       last;
    } item_t;

endpackage

>>> sv/ant32_front.sv
// Front part: radix register and per-character classification.
// Depends on ant32_pkg; feeds ant32_queue.
module ant32_front
    import ant32_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata,
    input  logic [7:0] char_code,
    input  logic       last_char,
    output item_t      item
);

    logic [1:0] radix_reg;
    logic [1:0] radix_next;

    always_comb
    begin
        radix_next = cfg_we ? cfg_wdata : radix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else
        begin
            radix_reg <= radix_next;
        end
    end

    logic       is_dec_digit;
    logic       is_lc_hex;
    logic       is_uc_hex;
    logic [7:0] dec_off;
    logic [7:0] lc_off;
    logic [7:0] uc_off;

    always_comb
    begin
        is_dec_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
        is_lc_hex    = (char_code >= CHAR_LC_A) && (char_code <= CHAR_LC_F);
        is_uc_hex    = (char_code >= CHAR_UC_A) && (char_code <= CHAR_UC_F);
        dec_off      = char_code - CHAR_ZERO;
        lc_off       = char_code - CHAR_LC_A + 8'd10;
        uc_off       = char_code - CHAR_UC_A + 8'd10;

        item.radix    = radix_reg;
        item.is_minus = (char_code == CHAR_MINUS);
        item.last     = last_char;
        item.digit_ok = 1'b0;
        item.digit    = dec_off[3:0];

        unique case (radix_reg)
            RADIX_BIN:
            begin
                item.digit_ok = (char_code == CHAR_ZERO) || (char_code == CHAR_ONE);
            end
            RADIX_HEX:
            begin
                item.digit_ok = is_dec_digit || is_lc_hex || is_uc_hex;
                if (is_lc_hex)
                begin
                    item.digit = lc_off[3:0];
                end
                else if (is_uc_hex)
                begin
                    item.digit = uc_off[3:0];
                end
            end
            default:
            begin
                item.digit_ok = is_dec_digit;
            end
        endcase
    end

endmodule

>>> sv/ant32_queue.sv
// Short queue of classified characters between front and back.
// Depends on ant32_pkg for the item type and depth.
module ant32_queue
    import ant32_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  not_full,
    input  logic  pop,
    output logic  not_empty,
    output item_t head_item
);

    item_t                  entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;

    assign not_full  = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> sv/ant32_back.sv
// Back part: digit accumulation, error tracking and the result register.
// Depends on ant32_pkg; takes items from ant32_queue.
module ant32_back
    import ant32_pkg::*;
#(
    parameter int MAX_TEXT_LEN = 255
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  item_t       item,
    output logic        item_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] value,
    output logic [1:0]  status,
    output logic [7:0]  error_position
);

    localparam int         CAP_INT = (MAX_TEXT_LEN < 255) ? MAX_TEXT_LEN : 255;
    localparam logic [7:0] IDX_CAP = 8'(CAP_INT);

    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic             minus_reg;
    logic             minus_next;
    logic [7:0]       idx_reg;
    logic [7:0]       idx_next;
    logic             bad_reg;
    logic             bad_next;
    logic [7:0]       bad_idx_reg;
    logic [7:0]       bad_idx_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [31:0]      value_reg;
    logic [31:0]      value_next;
    status_t          status_reg;
    status_t          status_next;
    logic [7:0]       errpos_reg;
    logic [7:0]       errpos_next;

    logic             out_free;
    logic             is_dec;
    logic             cur_bad;
    logic [PROD_W-1:0] prod;
    logic [ACC_W-1:0] acc_upd;
    logic             ovf_upd;
    logic             minus_upd;
    logic             bad_upd;
    logic [7:0]       bad_idx_upd;
    logic [8:0]       text_len;
    status_t          fin_status;
    logic [31:0]      fin_value;

    assign out_free       = !out_valid_reg || out_ready;
    // a non-final character never needs the result register
    assign item_pop       = item_valid && (!item.last || out_free);
    assign out_valid      = out_valid_reg;
    assign value          = value_reg;
    assign status         = status_reg;
    assign error_position = errpos_reg;

    // per-character update
    always_comb
    begin
        is_dec    = (item.radix != RADIX_BIN) && (item.radix != RADIX_HEX);
        cur_bad   = !item.digit_ok && !(is_dec && item.is_minus && (idx_reg == '0));
        prod      = (PROD_W'(acc_reg) << 3) + (PROD_W'(acc_reg) << 1)
                    + PROD_W'(item.digit);
        acc_upd   = acc_reg;
        ovf_upd   = ovf_reg;
        minus_upd = minus_reg;

        if (item.digit_ok)
        begin
            unique case (item.radix)
                RADIX_BIN:
                begin
                    acc_upd = {1'b0, acc_reg[30:0], item.digit[0]};
                end
                RADIX_HEX:
                begin
                    acc_upd = {1'b0, acc_reg[27:0], item.digit};
                end
                default:
                begin
                    if (prod > DEC_LIMIT)
                    begin
                        ovf_upd = 1'b1;
                        acc_upd = DEC_LIMIT[ACC_W-1:0];
                    end
                    else
                    begin
                        acc_upd = prod[ACC_W-1:0];
                    end
                end
            endcase
        end
        else if (is_dec && item.is_minus && (idx_reg == '0))
        begin
            minus_upd = 1'b1;
        end

        bad_upd     = bad_reg || cur_bad;
        bad_idx_upd = bad_reg ? bad_idx_reg : idx_reg;
        text_len    = {1'b0, idx_reg} + 9'd1;
    end

    // final checks, under the radix of the last character
    always_comb
    begin
        fin_status = ST_OK;
        fin_value  = '0;
        unique case (item.radix)
            RADIX_BIN:
            begin
                priority if (text_len != BIN_LEN)
                begin
                    fin_status = ST_LENGTH;
                end
                else if (bad_upd)
                begin
                    fin_status = ST_FORMAT;
                end
                else
                begin
                    fin_value = acc_upd[31:0];
                end
            end
            RADIX_HEX:
            begin
                priority if (bad_upd)
                begin
                    fin_status = ST_FORMAT;
                end
                else if (text_len != HEX_LEN)
                begin
                    fin_status = ST_LENGTH;
                end
                else
                begin
                    fin_value = acc_upd[31:0];
                end
            end
            default:
            begin
                priority if (bad_upd)
                begin
                    fin_status = ST_FORMAT;
                end
                else if (ovf_upd || (!minus_upd && (acc_upd > POS_MAX)))
                begin
                    fin_status = ST_RANGE;
                end
                else if (minus_upd)
                begin
                    fin_value = 32'd0 - acc_upd[31:0];
                end
                else
                begin
                    fin_value = acc_upd[31:0];
                end
            end
        endcase
    end

    always_comb
    begin
        acc_next       = acc_reg;
        ovf_next       = ovf_reg;
        minus_next     = minus_reg;
        idx_next       = idx_reg;
        bad_next       = bad_reg;
        bad_idx_next   = bad_idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        value_next     = value_reg;
        status_next    = status_reg;
        errpos_next    = errpos_reg;

        if (item_pop)
        begin
            if (item.last)
            begin
                // emit and clear for the next number
                acc_next       = '0;
                ovf_next       = 1'b0;
                minus_next     = 1'b0;
                idx_next       = '0;
                bad_next       = 1'b0;
                bad_idx_next   = '0;
                out_valid_next = 1'b1;
                value_next     = fin_value;
                status_next    = fin_status;
                errpos_next    = (fin_status == ST_FORMAT) ? bad_idx_upd : 8'd0;
            end
            else
            begin
                acc_next     = acc_upd;
                ovf_next     = ovf_upd;
                minus_next   = minus_upd;
                bad_next     = bad_upd;
                bad_idx_next = bad_idx_upd;
                if (idx_reg < IDX_CAP)
                begin
                    idx_next = idx_reg + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            minus_reg     <= 1'b0;
            idx_reg       <= '0;
            bad_reg       <= 1'b0;
            bad_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            ovf_reg       <= ovf_next;
            minus_reg     <= minus_next;
            idx_reg       <= idx_next;
            bad_reg       <= bad_next;
            bad_idx_reg   <= bad_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        status_reg <= status_next;
        errpos_reg <= errpos_next;
    end

endmodule

>>> sv/ascii_number_to_int32_core.sv
// ASCII number parser, top level: front classifier, item queue, back accumulator.
// Depends on ant32_pkg, ant32_front, ant32_queue and ant32_back.
//
// Parses one number of ASCII characters, one character per cycle on the input channel
// while in_ready is high, into a signed 32-bit value with a status (ok, format error
// with the position of the first bad character, wrong length, out of range); a result
// appears only for the character marked last. Sustained rate is one character per clock
// while the queue has room, set by the combinational shift-add in the back accumulator.
// A taken character is written into a queue entry register and is consumed by the
// accumulator from the queue head; a final character's result lands in the output
// register at the edge that consumes it. A two-entry queue between the classifier and
// the accumulator lets non-final characters keep flowing while a result waits; a final
// character waits in the queue until the output register frees, and input stalls once
// two characters wait. Write the radix register only while no number is in flight.
module ascii_number_to_int32_core
    import ant32_pkg::*;
#(
    parameter int MAX_TEXT_LEN = 255
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_code,
    input  logic        last_char,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] value,
    output logic [1:0]  status,
    output logic [7:0]  error_position
);

    item_t front_item;
    item_t head_item;
    logic  q_not_full;
    logic  q_not_empty;
    logic  q_pop;

    assign in_ready = q_not_full;

    ant32_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .char_code (char_code),
        .last_char (last_char),
        .item      (front_item)
    );

    ant32_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && q_not_full),
        .push_item (front_item),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (head_item)
    );

    ant32_back #(
        .MAX_TEXT_LEN (MAX_TEXT_LEN)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (q_not_empty),
        .item           (head_item),
        .item_pop       (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .value          (value),
        .status         (status),
        .error_position (error_position)
    );

endmodule

>>> sv/ant32_checker.sv
// Port-level checks for the ASCII number parser, bound to the top level.
// Depends on ant32_pkg for the status codes.
module ant32_checker
    import ant32_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] value,
    input logic [1:0]  status,
    input logic [7:0]  error_position
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value) && $stable(status)
            && $stable(error_position))
        else $error("result changed while stalled");

    a_err_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> (value == 32'd0))
        else $error("nonzero value with error status");

    a_pos_only_format: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_FORMAT) |-> (error_position == 8'd0))
        else $error("error position set without format error");

    // a pending transfer with no consumer cannot vanish
    a_out_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before transfer");

endmodule

bind ascii_number_to_int32_core ant32_checker u_ant32_checker (.*);
